@@ design/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Holds the cell layout, function codes, character codes and the sequencer
// states used by the console control and its screen memory.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Function codes carried by the request item.
  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // Character and attribute codes.
  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam logic [7:0] RESET_ATTR   = 8'h07;

  // Field widths of the items.
  localparam int FUNC_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int INDEX_W  = 11;

  // One screen cell: attribute in the upper byte, character in the lower.
  typedef struct packed {
    logic [BYTE_W-1:0] attr;
    logic [BYTE_W-1:0] chr;
  } cell_t;

  // Control sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_DRAIN,
    S_NL,
    S_RD,
    S_DONE
  } state_t;

endpackage

@@ design/tcw_ifs.sv @@
// ----------------------------------------------------------------------------
// tcw_ifs: request and result channels of the text console writer
// Valid/ready channels; an item moves on a rising edge with both high.
// ----------------------------------------------------------------------------
interface tcw_req_if;
  logic                          valid;
  logic                          ready;
  logic [tcw_pkg::FUNC_W-1:0]    func;
  logic [tcw_pkg::BYTE_W-1:0]    char_code;
  logic [tcw_pkg::INDEX_W-1:0]   cell_index;

  modport source (output valid, output func, output char_code, output cell_index,
                  input ready);
  modport sink   (input valid, input func, input char_code, input cell_index,
                  output ready);
endinterface

interface tcw_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [tcw_pkg::INDEX_W-1:0]   cursor_cell;
  logic [tcw_pkg::BYTE_W-1:0]    read_char;
  logic [tcw_pkg::BYTE_W-1:0]    read_attr;
  logic                          scrolled;

  modport source (output valid, output cursor_cell, output read_char,
                  output read_attr, output scrolled, input ready);
  modport sink   (input valid, input cursor_cell, input read_char,
                  input read_attr, input scrolled, output ready);
endinterface

@@ design/tcw_screen_ram.sv @@
// ----------------------------------------------------------------------------
// tcw_screen_ram: screen cell memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module tcw_screen_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  tcw_pkg::cell_t      wdata,
  input  logic [AW-1:0]       raddr,
  output tcw_pkg::cell_t      rdata
);

  tcw_pkg::cell_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ design/text_console_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_writer: text screen store with a write cursor
// Puts characters at the cursor, handles newline, scrolls up one line when
// the cursor passes the last cell, clears the screen and reads single cells.
// ----------------------------------------------------------------------------
//
//  Channel           Dir  Handshake        Contents
//  req               in   valid/ready      func, char_code, cell_index
//  rsp               out  valid/ready      cursor_cell, read_char, read_attr,
//                                          scrolled
//  color_attr_we/_data in write enable     attribute register, no read-back
//
//  A plain character is written on acceptance and goes to S_DONE; a newline
//  passes S_NL and a read S_RD first. A scroll or a clear runs a sweep over
//  the whole screen memory, one cell per cycle through the single write port.
//  After reset a clearing sweep writes spaces in attribute 0x07; no item is
//  accepted meanwhile. One item is worked on at a time; a new item is
//  accepted while the last result still waits in the output register.
// ----------------------------------------------------------------------------
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                       clk,
  input  logic                       rst,
  tcw_req_if.sink                    req,
  tcw_rsp_if.source                  rsp,
  input  logic                       color_attr_we,
  input  logic [tcw_pkg::BYTE_W-1:0] color_attr_data
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int KEEP  = CELLS - COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int COLW  = $clog2(COLUMNS);

  // Control registers.
  tcw_pkg::state_t state, state_next;
  logic [AW-1:0]   sweep_addr;
  logic            scroll_mode;
  logic            sweep_report;
  logic [7:0]      fill_attr;
  logic            p_valid;
  logic [AW-1:0]   cursor;
  logic [COLW-1:0] col;
  logic [7:0]      color_attr;
  logic            out_valid;

  // Payload registers.
  logic            p_copy;
  logic [AW-1:0]   p_addr;
  logic            rd_ok;
  logic [7:0]      res_char;
  logic [7:0]      res_attr;
  logic            res_scr;
  logic [10:0]     out_cursor;
  logic [7:0]      out_char;
  logic [7:0]      out_attr;
  logic            out_scr;

  // Memory ports.
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  tcw_pkg::cell_t  mem_wdata;
  logic [AW-1:0]   mem_raddr;
  tcw_pkg::cell_t  mem_rdata;

  // Decode and cursor advance.
  logic            accept;
  logic            put_char;
  logic            do_adv;
  logic            adv_nl;
  logic [AW:0]     adv_pos;
  logic            adv_wrap;
  logic            adv_past;
  logic [AW-1:0]   adv_cursor;
  logic [COLW-1:0] adv_col;
  logic            sweep_last;
  logic            sweep_copy;
  logic [AW:0]     sweep_src;
  logic            out_free;
  logic [31:0]     cursor_ext;

  tcw_screen_ram #(.DEPTH(CELLS), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign accept   = req.valid && req.ready;
  assign req.ready = (state == tcw_pkg::S_IDLE);
  assign put_char = accept && (req.func == tcw_pkg::FUNC_PUT) &&
                    (req.char_code != tcw_pkg::NEWLINE_CODE);
  assign adv_nl   = (state == tcw_pkg::S_NL);
  assign do_adv   = put_char || adv_nl;
  assign out_free = !out_valid || rsp.ready;

  // Cursor advance: next cell, or start of the next row on newline.
  assign adv_pos    = adv_nl ? ({1'b0, cursor} - (AW+1)'(col) + (AW+1)'(COLUMNS))
                             : ({1'b0, cursor} + 1'b1);
  assign adv_wrap   = adv_nl || (col == COLW'(COLUMNS - 1));
  assign adv_past   = (adv_pos >= (AW+1)'(CELLS));
  assign adv_cursor = adv_past ? AW'(KEEP) : adv_pos[AW-1:0];
  assign adv_col    = adv_wrap ? '0 : col + 1'b1;

  // Sweep address decode: copy from one row below, or fill.
  assign sweep_last = (sweep_addr == AW'(CELLS - 1));
  assign sweep_copy = scroll_mode && ({1'b0, sweep_addr} < (AW+1)'(KEEP));
  assign sweep_src  = {1'b0, sweep_addr} + (AW+1)'(COLUMNS);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      tcw_pkg::S_IDLE: begin
        if (accept) begin
          case (req.func)
            tcw_pkg::FUNC_PUT: begin
              if (req.char_code == tcw_pkg::NEWLINE_CODE) begin
                state_next = tcw_pkg::S_NL;
              end else if (adv_past) begin
                state_next = tcw_pkg::S_SWEEP;
              end else begin
                state_next = tcw_pkg::S_DONE;
              end
            end
            tcw_pkg::FUNC_CLEAR: state_next = tcw_pkg::S_SWEEP;
            tcw_pkg::FUNC_READ:  state_next = tcw_pkg::S_RD;
            default:             state_next = tcw_pkg::S_DONE;
          endcase
        end
      end
      tcw_pkg::S_NL:    state_next = adv_past ? tcw_pkg::S_SWEEP : tcw_pkg::S_DONE;
      tcw_pkg::S_SWEEP: state_next = sweep_last ? tcw_pkg::S_DRAIN : tcw_pkg::S_SWEEP;
      tcw_pkg::S_DRAIN: state_next = sweep_report ? tcw_pkg::S_DONE : tcw_pkg::S_IDLE;
      tcw_pkg::S_RD:    state_next = tcw_pkg::S_DONE;
      tcw_pkg::S_DONE:  state_next = out_free ? tcw_pkg::S_IDLE : tcw_pkg::S_DONE;
      default:          state_next = tcw_pkg::S_IDLE;
    endcase
  end

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cursor;
    mem_wdata = '{attr: color_attr, chr: req.char_code};
    mem_raddr = cursor;
    case (state)
      tcw_pkg::S_IDLE: begin
        if (req.func == tcw_pkg::FUNC_READ) begin
          mem_raddr = AW'(req.cell_index);
        end
      end
      tcw_pkg::S_SWEEP: mem_raddr = sweep_src[AW-1:0];
      default:          mem_raddr = cursor;
    endcase
    if (p_valid) begin
      // Sweep write stage: copied cell or blank in the fill attribute.
      mem_we    = 1'b1;
      mem_waddr = p_addr;
      mem_wdata = p_copy ? mem_rdata
                         : tcw_pkg::cell_t'{attr: fill_attr, chr: tcw_pkg::SPACE_CODE};
    end else if (adv_nl) begin
      // Newline blanks the character and keeps the attribute.
      mem_we    = 1'b1;
      mem_wdata = '{attr: mem_rdata.attr, chr: tcw_pkg::SPACE_CODE};
    end else if (put_char) begin
      mem_we    = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= tcw_pkg::S_SWEEP;
      sweep_addr   <= '0;
      scroll_mode  <= 1'b0;
      sweep_report <= 1'b0;
      fill_attr    <= tcw_pkg::RESET_ATTR;
      p_valid      <= 1'b0;
      cursor       <= '0;
      col          <= '0;
      color_attr   <= tcw_pkg::RESET_ATTR;
      out_valid    <= 1'b0;
    end else begin
      state   <= state_next;
      p_valid <= (state == tcw_pkg::S_SWEEP);
      if (color_attr_we) begin
        color_attr <= color_attr_data;
      end
      if (state == tcw_pkg::S_SWEEP) begin
        sweep_addr <= sweep_last ? '0 : sweep_addr + 1'b1;
      end
      if (accept && (req.func == tcw_pkg::FUNC_CLEAR)) begin
        scroll_mode  <= 1'b0;
        sweep_report <= 1'b1;
        fill_attr    <= color_attr;
        cursor       <= '0;
        col          <= '0;
      end
      if (do_adv) begin
        cursor <= adv_cursor;
        col    <= adv_col;
        if (adv_past) begin
          scroll_mode  <= 1'b1;
          sweep_report <= 1'b1;
          fill_attr    <= color_attr;
        end
      end
      if (state == tcw_pkg::S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign cursor_ext = 32'(cursor);

  // Payload registers: sweep stage, result fields and output register.
  always_ff @(posedge clk) begin
    p_copy <= sweep_copy;
    p_addr <= sweep_addr;
    if (accept) begin
      rd_ok    <= (int'(req.cell_index) < CELLS);
      res_char <= '0;
      res_attr <= '0;
      res_scr  <= 1'b0;
    end
    if (do_adv) begin
      res_scr <= adv_past;
    end
    if (state == tcw_pkg::S_RD) begin
      res_char <= rd_ok ? mem_rdata.chr  : '0;
      res_attr <= rd_ok ? mem_rdata.attr : '0;
    end
    if (state == tcw_pkg::S_DONE && out_free) begin
      out_cursor <= cursor_ext[10:0];
      out_char   <= res_char;
      out_attr   <= res_attr;
      out_scr    <= res_scr;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.cursor_cell = out_cursor;
  assign rsp.read_char   = out_char;
  assign rsp.read_attr   = out_attr;
  assign rsp.scrolled    = out_scr;

  // The sweep write stage is empty whenever a new item may be taken.
  a_idle_no_sweep_write: assert property (@(posedge clk) disable iff (rst)
    (state == tcw_pkg::S_IDLE) |-> (!p_valid && sweep_addr == '0))
    else $error("sweep write pending while idle");

  // The cursor stays on the screen and its column matches its range.
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (32'(cursor) < 32'(CELLS)) && (32'(col) < 32'(COLUMNS)))
    else $error("cursor or column out of range");

  // A scroll always leaves the cursor at the start of the bottom row.
  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
    (state == tcw_pkg::S_DONE && res_scr) |-> (cursor == AW'(KEEP) && col == '0))
    else $error("scroll left cursor away from bottom row start");

  // A finished result waiting in the output register is held until taken.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp.ready) |=> (out_valid && $stable(out_cursor) && $stable(out_scr)))
    else $error("waiting result changed");

endmodule

@@ bench/tb_text_console_writer.sv @@
// ----------------------------------------------------------------------------
// tb_text_console_writer: self-checking bench for the text console writer
// Drives put, newline, clear, read and unused-function items through the
// request channel and predicts every result from a local copy of the screen,
// the cursor and the attribute register. Each result on the response channel
// is checked field by field against the oldest prediction. Both channels
// idle at random, and one long output stall backs the block up.
// ----------------------------------------------------------------------------
module tb_text_console_writer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int CELLS       = COLUMNS * ROWS;
  localparam int CYCLE_LIMIT = 20_000_000;

  // The one code the block leaves without meaning.
  localparam logic [tcw_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct {
    logic [tcw_pkg::INDEX_W-1:0] cursor_cell;
    logic [tcw_pkg::BYTE_W-1:0]  read_char;
    logic [tcw_pkg::BYTE_W-1:0]  read_attr;
    logic                        scrolled;
  } console_result_t;

  logic clk;
  logic rst;
  logic                       color_attr_we;
  logic [tcw_pkg::BYTE_W-1:0] color_attr_data;

  tcw_req_if req_ch ();
  tcw_rsp_if rsp_ch ();

  text_console_writer #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .req            (req_ch),
    .rsp            (rsp_ch),
    .color_attr_we  (color_attr_we),
    .color_attr_data(color_attr_data)
  );

  // Local copy of the screen, the cursor and the attribute register.
  tcw_pkg::cell_t shadow_screen [CELLS];
  int             shadow_cursor;
  logic [7:0]     shadow_attr;

  console_result_t pending_results[$];
  int error_count;
  int cycle_count;
  bit burst_mode;
  int stall_len;
  int stall_tag;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Fills every cell with a space in the given attribute.
  function automatic void fill_shadow(input logic [7:0] attr);
    for (int i = 0; i < CELLS; i++) begin
      shadow_screen[i].chr  = tcw_pkg::SPACE_CODE;
      shadow_screen[i].attr = attr;
    end
  endfunction

  // Works out the result of one item and updates the local screen copy.
  function automatic console_result_t predict_console(input logic [1:0] func,
                                                      input logic [7:0] code,
                                                      input logic [10:0] idx);
    console_result_t res;
    int pos;
    res.read_char = '0;
    res.read_attr = '0;
    res.scrolled  = 1'b0;
    if (func == tcw_pkg::FUNC_PUT) begin
      pos = shadow_cursor % CELLS;
      if (code == tcw_pkg::NEWLINE_CODE) begin
        shadow_screen[pos].chr = tcw_pkg::SPACE_CODE;
        shadow_cursor = (pos / COLUMNS + 1) * COLUMNS;
      end else begin
        shadow_screen[pos].chr  = code;
        shadow_screen[pos].attr = shadow_attr;
        shadow_cursor = pos + 1;
      end
      // Past the last cell: move every line up and blank the bottom one.
      if (shadow_cursor >= CELLS) begin
        for (int i = 0; i < CELLS - COLUMNS; i++)
          shadow_screen[i] = shadow_screen[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
          shadow_screen[i].chr  = tcw_pkg::SPACE_CODE;
          shadow_screen[i].attr = shadow_attr;
        end
        shadow_cursor = CELLS - COLUMNS;
        res.scrolled  = 1'b1;
      end
    end else if (func == tcw_pkg::FUNC_CLEAR) begin
      fill_shadow(shadow_attr);
      shadow_cursor = 0;
    end else if (func == tcw_pkg::FUNC_READ) begin
      if (idx < CELLS) begin
        res.read_char = shadow_screen[idx].chr;
        res.read_attr = shadow_screen[idx].attr;
      end
    end
    res.cursor_cell = shadow_cursor[tcw_pkg::INDEX_W-1:0];
    return res;
  endfunction

  // Sender gap: mostly none or short, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (burst_mode || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // Offers one item, waits for its handshake and records the prediction.
  task automatic send_item(input logic [1:0] func, input logic [7:0] code,
                           input logic [10:0] idx);
    int gap;
    @(negedge clk);
    req_ch.valid      <= 1'b1;
    req_ch.func       <= func;
    req_ch.char_code  <= code;
    req_ch.cell_index <= idx;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    pending_results.push_back(predict_console(func, code, idx));
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Lowers valid and waits until every predicted result has been seen.
  task automatic drain_results();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Writes the attribute register once the block is idle.
  task automatic write_color_attr(input logic [7:0] value);
    drain_results();
    @(negedge clk);
    color_attr_we   <= 1'b1;
    color_attr_data <= value;
    @(negedge clk);
    color_attr_we   <= 1'b0;
    shadow_attr = value;
  endtask

  // Response ready: random runs high and low, plus a requested long hold-off.
  initial begin
    int high_left;
    int low_left;
    int hold_left;
    int seen_tag;
    rsp_ch.ready = 1'b0;
    high_left = 0;
    low_left  = 0;
    hold_left = 0;
    seen_tag  = 0;
    forever begin
      @(negedge clk);
      if (stall_tag != seen_tag) begin
        seen_tag  = stall_tag;
        hold_left = stall_len;
      end
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else if (high_left > 0) begin
        rsp_ch.ready <= 1'b1;
        high_left--;
      end else if (low_left > 0) begin
        rsp_ch.ready <= 1'b0;
        low_left--;
      end else begin
        high_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(0, 30);
        low_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                : $urandom_range(0, 3);
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Result checker: each accepted result against the oldest prediction.
  always @(posedge clk) begin
    console_result_t exp_res;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result with no prediction waiting: cursor_cell %0d",
               rsp_ch.cursor_cell);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (rsp_ch.cursor_cell !== exp_res.cursor_cell) begin
          $error("cursor_cell expected %0d got %0d", exp_res.cursor_cell,
                 rsp_ch.cursor_cell);
          error_count++;
        end
        if (rsp_ch.read_char !== exp_res.read_char) begin
          $error("read_char expected %0h got %0h", exp_res.read_char,
                 rsp_ch.read_char);
          error_count++;
        end
        if (rsp_ch.read_attr !== exp_res.read_attr) begin
          $error("read_attr expected %0h got %0h", exp_res.read_attr,
                 rsp_ch.read_attr);
          error_count++;
        end
        if (rsp_ch.scrolled !== exp_res.scrolled) begin
          $error("scrolled expected %0b got %0b", exp_res.scrolled,
                 rsp_ch.scrolled);
          error_count++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_text_console_writer NOT OK");
      $finish;
    end
  end

  // Reset contents, read past the screen and the unused function code.
  task automatic test_reset_and_ranges();
    send_item(tcw_pkg::FUNC_READ, 8'h00, 11'd0);
    send_item(tcw_pkg::FUNC_READ, 8'hFF, 11'd1999);
    send_item(tcw_pkg::FUNC_READ, 8'h00, 11'd2000);
    send_item(tcw_pkg::FUNC_READ, 8'hA5, 11'd2047);
    send_item(FUNC_UNUSED, 8'hFF, 11'h7FF);
    send_item(FUNC_UNUSED, 8'h00, 11'd0);
  endtask

  // Extreme character bytes and a newline that keeps the cell attribute.
  task automatic test_put_and_newline();
    write_color_attr(8'hFF);
    send_item(tcw_pkg::FUNC_PUT, 8'h00, 11'h7FF);
    send_item(tcw_pkg::FUNC_PUT, 8'hFF, 11'd0);
    write_color_attr(8'h00);
    send_item(tcw_pkg::FUNC_PUT, tcw_pkg::NEWLINE_CODE, 11'd0);
    send_item(tcw_pkg::FUNC_READ, 8'h00, 11'd0);
    send_item(tcw_pkg::FUNC_READ, 8'h00, 11'd1);
    send_item(tcw_pkg::FUNC_READ, 8'h00, 11'd2);
    send_item(tcw_pkg::FUNC_PUT, 8'h55, 11'h555);
    send_item(tcw_pkg::FUNC_READ, 8'hAA, 11'd80);
  endtask

  // Clear in two attributes, then check the corners of the screen.
  task automatic test_clear();
    write_color_attr(8'hA5);
    send_item(tcw_pkg::FUNC_CLEAR, 8'hFF, 11'h7FF);
    send_item(tcw_pkg::FUNC_READ, 8'h00, 11'd0);
    send_item(tcw_pkg::FUNC_READ, 8'h00, 11'd1999);
    write_color_attr(8'h5A);
    send_item(tcw_pkg::FUNC_PUT, 8'hAA, 11'd0);
    send_item(tcw_pkg::FUNC_CLEAR, 8'h00, 11'd0);
    send_item(tcw_pkg::FUNC_READ, 8'h00, 11'd0);
  endtask

  // Random cell index: mostly on screen, some near the cursor or past the end.
  function automatic logic [10:0] pick_index();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 11'($urandom_range(0, CELLS - 1));
    if (roll < 88) return 11'((shadow_cursor + CELLS - $urandom_range(0, 3)) % CELLS);
    return 11'($urandom_range(CELLS - 10, 2047));
  endfunction

  // Random text in lines ended by newlines, with reads, clears and noise.
  task automatic test_random_text(input int item_total);
    int sent;
    int line_len;
    int roll;
    sent = 0;
    while (sent < item_total) begin
      burst_mode = ($urandom_range(0, 4) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 80) line_len = $urandom_range(0, 15);
      else if (roll < 95) line_len = $urandom_range(16, 79);
      else line_len = $urandom_range(80, 170);
      for (int k = 0; k < line_len; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 84) begin
          send_item(tcw_pkg::FUNC_PUT, 8'($urandom_range(0, 255)),
                    11'($urandom_range(0, 2047)));
          sent++;
        end else if (roll < 97) begin
          send_item(tcw_pkg::FUNC_READ, 8'($urandom_range(0, 255)), pick_index());
          sent++;
        end else begin
          send_item(FUNC_UNUSED, 8'($urandom_range(0, 255)),
                    11'($urandom_range(0, 2047)));
        end
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        send_item(tcw_pkg::FUNC_CLEAR, 8'($urandom_range(0, 255)),
                  11'($urandom_range(0, 2047)));
        sent++;
      end else if (roll < 92) begin
        send_item(tcw_pkg::FUNC_PUT, tcw_pkg::NEWLINE_CODE,
                  11'($urandom_range(0, 2047)));
        sent++;
      end
    end
    burst_mode = 1'b0;
  endtask

  // Long output hold-off while items keep coming, so the input stalls.
  task automatic test_output_backpressure();
    drain_results();
    @(negedge clk);
    stall_len = 3000;
    stall_tag++;
    burst_mode = 1'b1;
    for (int k = 0; k < 12; k++) begin
      if (k % 3 == 2)
        send_item(tcw_pkg::FUNC_READ, 8'h00, pick_index());
      else
        send_item(tcw_pkg::FUNC_PUT, 8'($urandom_range(0, 255)), 11'd0);
    end
    burst_mode = 1'b0;
  endtask

  // Test sequence.
  initial begin
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.func       = tcw_pkg::FUNC_PUT;
    req_ch.char_code  = '0;
    req_ch.cell_index = '0;
    color_attr_we     = 1'b0;
    color_attr_data   = '0;
    error_count       = 0;
    cycle_count       = 0;
    burst_mode        = 1'b0;
    stall_len         = 0;
    stall_tag         = 0;
    shadow_attr       = tcw_pkg::RESET_ATTR;
    shadow_cursor     = 0;
    fill_shadow(tcw_pkg::RESET_ATTR);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // The block clears its screen after reset before it takes any item.
    do @(posedge clk); while (req_ch.ready !== 1'b1);

    test_reset_and_ranges();
    test_put_and_newline();
    test_clear();
    write_color_attr(tcw_pkg::RESET_ATTR);
    test_random_text(300);
    write_color_attr(8'($urandom_range(0, 255)));
    test_output_backpressure();
    test_random_text(300);
    write_color_attr(8'hFF);
    test_random_text(200);
    write_color_attr(8'h00);
    test_random_text(200);

    drain_results();
    repeat (50) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb_text_console_writer OK");
    end else begin
      $display("tb_text_console_writer NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/tcw_pkg.sv
design/tcw_ifs.sv
design/tcw_screen_ram.sv
design/text_console_writer.sv
bench/tb_text_console_writer.sv
